>>> design/pqrs_pkg.sv
package pqrs_pkg;

	localparam int QUEUE_DEPTH_DEF = 5;
	localparam int STACK_DEPTH_DEF = 3;
	localparam int ID_WIDTH_DEF    = 16;
	localparam int TYPE_W          = 2;

	typedef enum logic [1:0] {
		K_ADD     = 2'd0,
		K_PLAY    = 2'd1,
		K_RESERVE = 2'd2,
		K_USE     = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_QUEUE_EMPTY = 3'd1,
		ST_STACK_FULL  = 3'd2,
		ST_STACK_EMPTY = 3'd3,
		ST_QUEUE_FULL  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_NEXT = 2'd1,
		CELL_PREV = 2'd2,
		CELL_LOAD = 2'd3
	} cell_op_t;

	// Row control: shift toward cell 0, shift away from cell 0, load one cell.
	typedef struct packed {
		logic shift_dn;
		logic shift_up;
		logic load;
	} row_ctl_t;

	// Type table I, O, T, L, I; indexes past the table give I.
	function automatic logic [TYPE_W-1:0] type_of(input logic [2:0] idx);
		logic [TYPE_W-1:0] t;
		case (idx)
			3'd1: t = 2'd1;
			3'd2: t = 2'd2;
			3'd3: t = 2'd3;
			default: t = 2'd0;
		endcase
		return t;
	endfunction

endpackage

>>> design/pqrs_cell.sv
module pqrs_cell #(
	parameter int WIDTH = 18
) (
	input  logic                clk,
	input  pqrs_pkg::cell_op_t  op,
	input  logic [WIDTH-1:0]    prev_data,
	input  logic [WIDTH-1:0]    next_data,
	input  logic [WIDTH-1:0]    load_data,
	output logic [WIDTH-1:0]    data
);
	import pqrs_pkg::*;

	logic [WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		case (op)
			CELL_NEXT: data_q <= next_data;
			CELL_PREV: data_q <= prev_data;
			CELL_LOAD: data_q <= load_data;
			default:   data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

>>> design/pqrs_row.sv
module pqrs_row #(
	parameter int DEPTH = 5,
	parameter int WIDTH = 18,
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  pqrs_pkg::row_ctl_t  ctl,
	input  logic [IDX_W-1:0]    load_idx,
	input  logic [WIDTH-1:0]    load_data,
	output logic [WIDTH-1:0]    head
);
	import pqrs_pkg::*;

	logic [WIDTH-1:0] cell_data [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_op_t         op;
		logic [WIDTH-1:0] prev_d;
		logic [WIDTH-1:0] next_d;

		assign prev_d = (i == 0) ? cell_data[i] : cell_data[(i == 0) ? 0 : i-1];
		assign next_d = (i == DEPTH-1) ? cell_data[i] : cell_data[(i == DEPTH-1) ? i : i+1];

		// load wins over shift so a refill lands after the row moves
		always_comb begin
			if (ctl.load && load_idx == IDX_W'(i)) begin
				op = CELL_LOAD;
			end else if (ctl.shift_dn) begin
				op = CELL_NEXT;
			end else if (ctl.shift_up) begin
				op = CELL_PREV;
			end else begin
				op = CELL_HOLD;
			end
		end

		pqrs_cell #(.WIDTH(WIDTH)) u_cell (
			.clk       (clk),
			.op        (op),
			.prev_data (prev_d),
			.next_data (next_d),
			.load_data (load_data),
			.data      (cell_data[i])
		);
	end

	assign head = cell_data[0];

endmodule

>>> design/piece_queue_with_reserve_stack.sv
// Result: each accepted command beat is registered and its result beat shows in the next cycle.
// Throughput: one command per cycle; the output register refills in the same
// cycle it is drained, so only a stalled result holds off new commands.
// Reset: arst_n clears queue and stack fill, next identifier and output valid;
// cell contents are left as they are and only read once written.
module piece_queue_with_reserve_stack #(
	parameter int QUEUE_DEPTH = pqrs_pkg::QUEUE_DEPTH_DEF,
	parameter int STACK_DEPTH = pqrs_pkg::STACK_DEPTH_DEF,
	parameter int ID_WIDTH    = pqrs_pkg::ID_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [2:0]  new_type,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [1:0]  piece_type,
	output logic [15:0] piece_id,
	output logic [2:0]  queue_count,
	output logic [1:0]  stack_count
);
	import pqrs_pkg::*;

	localparam int PIECE_W = TYPE_W + ID_WIDTH;
	localparam int QIDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int SIDX_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int QF_W    = $clog2(QUEUE_DEPTH + 1);
	localparam int SF_W    = $clog2(STACK_DEPTH + 1);

	// Fill counts and the identifier counter
	logic [QF_W-1:0]     q_fill_q;
	logic [SF_W-1:0]     s_fill_q;
	logic [ID_WIDTH-1:0] next_id_q;

	// Result register
	logic                out_valid_q;
	status_t             status_q;
	logic [TYPE_W-1:0]   type_q;
	logic [ID_WIDTH-1:0] id_q;

	logic                fire;
	kind_t               kind_v;
	row_ctl_t            q_ctl;
	row_ctl_t            s_ctl;
	logic [QIDX_W-1:0]   q_load_idx;
	logic [PIECE_W-1:0]  q_head;
	logic [PIECE_W-1:0]  s_head;
	logic [PIECE_W-1:0]  new_piece;
	logic                draw;
	logic                take_q;
	logic                take_s;
	status_t             status_n;
	logic [QF_W-1:0]     q_fill_n;
	logic [SF_W-1:0]     s_fill_n;
	logic                q_empty;
	logic                q_full;
	logic                s_empty;
	logic                s_full;

	// Take a new beat whenever the result slot is free or being drained.
	assign in_ready = !out_valid_q || out_ready;
	assign fire     = in_valid && in_ready;
	assign kind_v   = kind_t'(kind);

	assign q_empty = (q_fill_q == '0);
	assign q_full  = (q_fill_q == QF_W'(QUEUE_DEPTH));
	assign s_empty = (s_fill_q == '0);
	assign s_full  = (s_fill_q == SF_W'(STACK_DEPTH));

	assign new_piece = {type_of(new_type), next_id_q};

	// Decode one command into row moves. The queue front sits in cell 0, so a
	// removal shifts the row down and the refill lands at the last filled slot.
	// The stack top also sits in cell 0: push shifts up, pop shifts down.
	always_comb begin
		q_ctl      = '0;
		s_ctl      = '0;
		q_load_idx = '0;
		draw       = 1'b0;
		take_q     = 1'b0;
		take_s     = 1'b0;
		status_n   = ST_OK;
		q_fill_n   = q_fill_q;
		s_fill_n   = s_fill_q;
		if (fire) begin
			case (kind_v)
				K_ADD: begin
					// an identifier is drawn even when the piece is dropped
					draw = 1'b1;
					if (q_full) begin
						status_n = ST_QUEUE_FULL;
					end else begin
						q_ctl.load = 1'b1;
						q_load_idx = QIDX_W'(q_fill_q);
						q_fill_n   = q_fill_q + 1'b1;
					end
				end
				K_PLAY: begin
					if (q_empty) begin
						status_n = ST_QUEUE_EMPTY;
					end else begin
						take_q         = 1'b1;
						draw           = 1'b1;
						q_ctl.shift_dn = 1'b1;
						q_ctl.load     = 1'b1;
						q_load_idx     = QIDX_W'(q_fill_q - 1'b1);
					end
				end
				K_RESERVE: begin
					if (q_empty) begin
						status_n = ST_QUEUE_EMPTY;
					end else if (s_full) begin
						status_n = ST_STACK_FULL;
					end else begin
						take_q         = 1'b1;
						draw           = 1'b1;
						q_ctl.shift_dn = 1'b1;
						q_ctl.load     = 1'b1;
						q_load_idx     = QIDX_W'(q_fill_q - 1'b1);
						s_ctl.shift_up = 1'b1;
						s_ctl.load     = 1'b1;
						s_fill_n       = s_fill_q + 1'b1;
					end
				end
				K_USE: begin
					if (s_empty) begin
						status_n = ST_STACK_EMPTY;
					end else begin
						take_s         = 1'b1;
						s_ctl.shift_dn = 1'b1;
						s_fill_n       = s_fill_q - 1'b1;
					end
				end
				default: begin
					status_n = ST_OK;
				end
			endcase
		end
	end

	pqrs_row #(.DEPTH(QUEUE_DEPTH), .WIDTH(PIECE_W)) u_queue (
		.clk       (clk),
		.ctl       (q_ctl),
		.load_idx  (q_load_idx),
		.load_data (new_piece),
		.head      (q_head)
	);

	pqrs_row #(.DEPTH(STACK_DEPTH), .WIDTH(PIECE_W)) u_stack (
		.clk       (clk),
		.ctl       (s_ctl),
		.load_idx  (SIDX_W'(0)),
		.load_data (q_head),
		.head      (s_head)
	);

	// Control state: fills, identifier counter and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_fill_q    <= '0;
			s_fill_q    <= '0;
			next_id_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			q_fill_q <= q_fill_n;
			s_fill_q <= s_fill_n;
			if (draw) begin
				next_id_q <= next_id_q + 1'b1;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload: hold while stalled, load on every accepted beat.
	always_ff @(posedge clk) begin
		if (fire) begin
			status_q <= status_n;
			if (take_q) begin
				type_q <= q_head[PIECE_W-1 -: TYPE_W];
				id_q   <= q_head[ID_WIDTH-1:0];
			end else if (take_s) begin
				type_q <= s_head[PIECE_W-1 -: TYPE_W];
				id_q   <= s_head[ID_WIDTH-1:0];
			end else begin
				type_q <= '0;
				id_q   <= '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign piece_type  = type_q;
	assign piece_id    = 16'(id_q);
	assign queue_count = 3'(q_fill_q);
	assign stack_count = 2'(s_fill_q);

	a_qfill_range: assert property (@(posedge clk) disable iff (!arst_n)
		q_fill_q <= QF_W'(QUEUE_DEPTH))
		else $error("queue fill beyond depth");

	a_sfill_range: assert property (@(posedge clk) disable iff (!arst_n)
		s_fill_q <= SF_W'(STACK_DEPTH))
		else $error("stack fill beyond depth");

	a_add_draws_id: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && kind_v == K_ADD) |=> (next_id_q == $past(next_id_q) + 1'b1))
		else $error("add did not advance the identifier");

	a_count_tracks_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (queue_count == 3'(q_fill_q) && stack_count == 2'(s_fill_q)))
		else $error("reported counts differ from fill");

endmodule

>>> bench/pqrs_checker.sv
`timescale 1ns / 1ps

module pqrs_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [2:0]  new_type,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  status,
	input  logic [1:0]  piece_type,
	input  logic [15:0] piece_id,
	input  logic [2:0]  queue_count,
	input  logic [1:0]  stack_count,
	input  logic        report,
	output int          fail_count,
	output int          outstanding
);
	import pqrs_pkg::*;

	localparam int QD = QUEUE_DEPTH_DEF;
	localparam int SD = STACK_DEPTH_DEF;

	typedef struct packed {
		status_t     st;
		logic [1:0]  ptype;
		logic [15:0] pid;
		logic [2:0]  qcnt;
		logic [1:0]  scnt;
	} outcome_t;

	logic [1:0]  q_type [QD];
	logic [15:0] q_id   [QD];
	int          q_head, q_tail, q_fill;
	logic [1:0]  s_type [SD];
	logic [15:0] s_id   [SD];
	int          s_fill;
	logic [15:0] id_next;

	outcome_t    due_q [$];
	outcome_t    seen, want;
	int          kind_hits   [4];
	int          status_hits [5];
	int          id_wraps;
	int          cmd_beats;

	initial begin
		fail_count = 0;
		id_wraps   = 0;
		cmd_beats  = 0;
		foreach (kind_hits[i]) kind_hits[i] = 0;
		foreach (status_hits[i]) status_hits[i] = 0;
	end

	// Piece table I, O, T, L, then I for every index past it.
	function automatic logic [1:0] lookup_type(input logic [2:0] idx);
		logic [1:0] t;
		t = 2'd0;
		if (idx >= 3'd1 && idx <= 3'd3)
			t = idx[1:0];
		return t;
	endfunction

	// Draw an identifier always; enqueue only if there is room.
	function automatic bit refill(input logic [2:0] idx);
		logic [15:0] id;
		id = id_next;
		id_next = id_next + 16'd1;
		if (id_next == 16'd0)
			id_wraps++;
		if (q_fill >= QD)
			return 1'b0;
		q_type[q_tail] = lookup_type(idx);
		q_id[q_tail]   = id;
		q_tail         = (q_tail + 1) % QD;
		q_fill++;
		return 1'b1;
	endfunction

	function automatic void take_front(output logic [1:0] t, output logic [15:0] id);
		t      = q_type[q_head];
		id     = q_id[q_head];
		q_head = (q_head + 1) % QD;
		q_fill--;
	endfunction

	function automatic outcome_t apply_command(input kind_t k, input logic [2:0] idx);
		outcome_t o;
		o = '0;
		o.st = ST_OK;
		case (k)
			K_ADD: begin
				if (!refill(idx))
					o.st = ST_QUEUE_FULL;
			end
			K_PLAY: begin
				if (q_fill == 0) begin
					o.st = ST_QUEUE_EMPTY;
				end else begin
					take_front(o.ptype, o.pid);
					void'(refill(idx));
				end
			end
			K_RESERVE: begin
				if (q_fill == 0) begin
					o.st = ST_QUEUE_EMPTY;
				end else if (s_fill >= SD) begin
					o.st = ST_STACK_FULL;
				end else begin
					take_front(o.ptype, o.pid);
					s_type[s_fill] = o.ptype;
					s_id[s_fill]   = o.pid;
					s_fill++;
					void'(refill(idx));
				end
			end
			default: begin
				if (s_fill == 0) begin
					o.st = ST_STACK_EMPTY;
				end else begin
					s_fill--;
					o.ptype = s_type[s_fill];
					o.pid   = s_id[s_fill];
				end
			end
		endcase
		o.qcnt = q_fill[2:0];
		o.scnt = s_fill[1:0];
		return o;
	endfunction

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			fail_count++;
			$error("%s: expected %0d, actual %0d", name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_head = 0;
			q_tail = 0;
			q_fill = 0;
			s_fill = 0;
			id_next = '0;
			due_q.delete();
			outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				seen.st    = status_t'(status);
				seen.ptype = piece_type;
				seen.pid   = piece_id;
				seen.qcnt  = queue_count;
				seen.scnt  = stack_count;
				if (due_q.size() == 0) begin
					fail_count++;
					$error("result beat with no command waiting: status %0d, piece_id %0d",
						status, piece_id);
				end else begin
					want = due_q.pop_front();
					check_field("status", want.st, seen.st);
					check_field("piece_type", want.ptype, seen.ptype);
					check_field("piece_id", want.pid, seen.pid);
					check_field("queue_count", want.qcnt, seen.qcnt);
					check_field("stack_count", want.scnt, seen.scnt);
				end
			end
			if (in_valid && in_ready) begin
				due_q.push_back(apply_command(kind_t'(kind), new_type));
				cmd_beats++;
				kind_hits[kind]++;
				status_hits[int'(due_q[$].st)]++;
			end
			outstanding <= due_q.size();
		end
	end

	always @(posedge report) begin
		$display("covered %0d commands: %0d add, %0d play, %0d reserve, %0d use; id wrapped %0d time(s)",
			cmd_beats, kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3], id_wraps);
		$display("outcomes: %0d ok, %0d queue empty, %0d stack full, %0d stack empty, %0d queue full",
			status_hits[0], status_hits[1], status_hits[2], status_hits[3], status_hits[4]);
	end

endmodule

>>> bench/piece_queue_with_reserve_stack_tb.sv
`timescale 1ns / 1ps

module piece_queue_with_reserve_stack_tb;
	import pqrs_pkg::*;

	// Cycles with no beat on either channel before the run is declared hung.
	// Longest honest quiet spell is a sender gap plus a receiver stall.
	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_BEATS = 1500;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  kind;
	logic [2:0]  new_type;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  status;
	logic [1:0]  piece_type;
	logic [15:0] piece_id;
	logic [2:0]  queue_count;
	logic [1:0]  stack_count;
	logic        report;

	int          fail_count;
	int          outstanding;

	logic [7:0]  ready_mask;
	logic [7:0]  ready_phase;
	int          idle_cycles = 0;

	always #6 clk = ~clk;

	piece_queue_with_reserve_stack u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.new_type    (new_type),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.piece_type  (piece_type),
		.piece_id    (piece_id),
		.queue_count (queue_count),
		.stack_count (stack_count)
	);

	pqrs_checker u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (kind),
		.new_type      (new_type),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.piece_type    (piece_type),
		.piece_id      (piece_id),
		.queue_count   (queue_count),
		.stack_count   (stack_count),
		.report        (report),
		.fail_count    (fail_count),
		.outstanding   (outstanding)
	);

	// Result side: replay an 8-bit ready mask, one bit per cycle, and draw
	// a new mask as the low five phase bits wrap. A third of the masks are
	// all ones, giving long stretches with no stall; the rest never go fully dark.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready   <= 1'b0;
			ready_mask  <= 8'hFF;
			ready_phase <= '0;
		end else begin
			out_ready   <= ready_mask[ready_phase[2:0]];
			ready_phase <= ready_phase + 8'd1;
			if (ready_phase[4:0] == 5'd31)
				ready_mask <= ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
		end
	end

	// Watchdog: reset the count on any beat, bail out if it runs too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("piece_queue_with_reserve_stack_tb failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Hold the command on the bus until it is taken. Call at a rising edge;
	// return at the edge where the beat was accepted.
	task automatic send_beat(input kind_t k, input logic [2:0] t);
		in_valid <= 1'b1;
		kind     <= k;
		new_type <= t;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Drop valid and hold until every expected result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	// Command mix per mode: 0 even, 1 fill-heavy, 2 drain-heavy, 3 stack churn.
	// Skewed mixes push the queue and stack against both of their limits.
	function automatic kind_t pick_kind(input int mode);
		int    roll;
		kind_t k;
		roll = $urandom_range(0, 99);
		case (mode)
			1:       k = (roll < 60) ? K_ADD : (roll < 75) ? K_PLAY :
				(roll < 90) ? K_RESERVE : K_USE;
			2:       k = (roll < 10) ? K_ADD : (roll < 40) ? K_PLAY :
				(roll < 70) ? K_RESERVE : K_USE;
			3:       k = (roll < 20) ? K_ADD : (roll < 30) ? K_PLAY :
				(roll < 65) ? K_RESERVE : K_USE;
			default: k = kind_t'(roll % 4);
		endcase
		return k;
	endfunction

	// Bursts of random length, random gaps between most of them, an
	// occasional full drain so that commands also land on an idle block.
	task automatic run_random(input int count);
		int sent;
		int mode;
		int burst;
		sent = 0;
		mode = 0;
		while (sent < count) begin
			if ($urandom_range(0, 3) == 0)
				mode = $urandom_range(0, 3);
			burst = $urandom_range(1, 24);
			repeat (burst) begin
				send_beat(pick_kind(mode), 3'($urandom_range(0, 7)));
				sent++;
			end
			if ($urandom_range(0, 39) == 0) begin
				drain_results();
			end else if ($urandom_range(0, 4) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12))
					@(posedge clk);
			end
		end
	endtask

	initial begin
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		kind     <= K_ADD;
		new_type <= 3'd0;
		report   <= 1'b0;
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty-side errors straight out of reset: play and reserve on an
		// empty queue, use on an empty stack.
		send_beat(K_PLAY, 3'd1);
		send_beat(K_RESERVE, 3'd2);
		send_beat(K_USE, 3'd3);
		// Fill the queue with every table index and the first one past it, then
		// overflow it with more out-of-table indexes; each overflow still burns an identifier.
		send_beat(K_ADD, 3'd0);
		send_beat(K_ADD, 3'd1);
		send_beat(K_ADD, 3'd2);
		send_beat(K_ADD, 3'd3);
		send_beat(K_ADD, 3'd4);
		send_beat(K_ADD, 3'd5);
		send_beat(K_ADD, 3'd7);
		// Fill the stack, then hit the full-stack refusal.
		send_beat(K_RESERVE, 3'd6);
		send_beat(K_RESERVE, 3'd3);
		send_beat(K_RESERVE, 3'd1);
		send_beat(K_RESERVE, 3'd2);
		// Play with refill, then pop the stack dry and once more.
		send_beat(K_PLAY, 3'd2);
		send_beat(K_PLAY, 3'd7);
		send_beat(K_USE, 3'd0);
		send_beat(K_USE, 3'd4);
		send_beat(K_USE, 3'd5);
		send_beat(K_USE, 3'd6);
		drain_results();

		run_random(RANDOM_BEATS);
		drain_results();

		// Watch for any stray result beat before the report.
		repeat (4)
			@(posedge clk);
		report <= 1'b1;
		@(posedge clk);
		@(posedge clk);
		if (fail_count == 0)
			$display("piece_queue_with_reserve_stack_tb passed");
		else
			$display("piece_queue_with_reserve_stack_tb failed");
		$finish;
	end

endmodule
